// ===== sv/substring_search_engine_assert.svh =====
// Assertion macros for the substring search engine.
`ifndef SUBSTRING_SEARCH_ENGINE_ASSERT_SVH
`define SUBSTRING_SEARCH_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sse_pkg.sv =====
// Shared types and constants of the substring search engine.
`default_nettype none
package sse_pkg;

   localparam int POS_W            = 21;
   localparam int NEEDLE_REG_BYTES = 8;
   localparam int NEEDLE_REG_W     = 8 * NEEDLE_REG_BYTES;
   localparam int NLEN_W           = 4;
   localparam int CSR_ADDR_W       = 2;
   localparam int REQ_DATA_W       = 8;
   localparam int RSP_DATA_W       = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NEEDLE_BYTES  = 2'd0,
      CSR_NEEDLE_LENGTH = 2'd1,
      CSR_START_OFFSET  = 2'd2,
      CSR_SEARCH_MODE   = 2'd3
   } csr_index_type;

endpackage
`default_nettype wire

// ===== sv/substring_search_engine.sv =====
// Streaming first/last match substring search over a byte stream.
//
// Haystack bytes enter on the req_ stream, one transfer per cycle with no gaps
// required: each transfer is compared against the configured needle over a
// sliding window of NEEDLE_BYTES bytes while it sits in the input register.
// Sustained rate is one byte per cycle; the only stall comes from an
// end-of-text transfer waiting for the result register when the previous
// result has not been taken. One rsp_ transfer is produced for each
// end-of-text item; rsp_tvalid rises once that item has left the input
// register and been loaded into the result register.
// Configuration must be written through csr_ only while no text is in flight; the block does not check this.
`default_nettype none
`include "substring_search_engine_assert.svh"
module substring_search_engine #(
   parameter int              NEEDLE_BYTES    = 8,
   parameter longint unsigned MAX_TEXT_LENGTH = 1048576
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tdata: text_byte[7:0]
   input  wire logic [sse_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: has_byte
   input  wire logic                               req_tuser,
   input  wire logic                               req_tlast,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // tdata: found[0], match_position[21:1], too_long[22], zero[23]
   output logic [sse_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_we,
   input  wire logic [sse_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [sse_pkg::NEEDLE_REG_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(MAX_TEXT_LENGTH + 1);
   localparam int CMP_W = (CNT_W > sse_pkg::POS_W) ? CNT_W : sse_pkg::POS_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT_LENGTH);

   logic [sse_pkg::NEEDLE_REG_W-1:0] needle_ff;
   logic [sse_pkg::NLEN_W-1:0]       nlen_ff;
   logic [sse_pkg::POS_W-1:0]        start_ff;
   logic                             mode_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_has_ff;
   logic       s1_eot_ff;
   logic       s1_adv;

   logic [7:0]               window_ff [NEEDLE_BYTES];
   logic [7:0]               window_in [NEEDLE_BYTES];
   logic [CNT_W-1:0]         count_ff, count_in, count_step;
   logic                     seen_ff, seen_in, seen_step;
   logic [sse_pkg::POS_W-1:0] best_ff, best_in, best_step;
   logic                     ovf_ff, ovf_in, ovf_step;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [sse_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [7:0]               needle_arr [NEEDLE_BYTES];
   logic [sse_pkg::NLEN_W-1:0] len_act;
   logic                     full, take, eq_hit, hit;
   logic [CNT_W-1:0]         pos;
   logic [CMP_W-1:0]         pos_ext, start_ext, count_ext, empty_pos;
   logic                     found;
   logic [sse_pkg::POS_W-1:0] out_pos;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff <= '0;
         nlen_ff   <= '0;
         start_ff  <= '0;
         mode_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (sse_pkg::csr_index_type'(csr_addr))
            sse_pkg::CSR_NEEDLE_BYTES:  needle_ff <= csr_wdata;
            sse_pkg::CSR_NEEDLE_LENGTH: nlen_ff   <= csr_wdata[sse_pkg::NLEN_W-1:0];
            sse_pkg::CSR_START_OFFSET:  start_ff  <= csr_wdata[sse_pkg::POS_W-1:0];
            sse_pkg::CSR_SEARCH_MODE:   mode_ff   <= csr_wdata[0];
            default:                    needle_ff <= needle_ff;
         endcase
      end
   end

   // Needle bytes past the register compare as zero
   for (genvar k = 0; k < NEEDLE_BYTES; k++) begin : g_needle
      if (k < sse_pkg::NEEDLE_REG_BYTES) begin : g_reg
         assign needle_arr[k] = needle_ff[8*k +: 8];
      end else begin : g_zero
         assign needle_arr[k] = 8'd0;
      end
   end

   assign len_act = (32'(nlen_ff) > NEEDLE_BYTES) ? sse_pkg::NLEN_W'(NEEDLE_BYTES) : nlen_ff;

   // Input register
   assign s1_adv     = s1_valid_ff && (!s1_eot_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff <= req_tdata;
         s1_has_ff  <= req_tuser;
         s1_eot_ff  <= req_tlast;
      end
   end

   // Window compare and text state update
   always_comb begin
      logic eq_l;
      full       = (count_ff == CNT_MAX);
      take       = s1_has_ff && !full;
      window_in  = window_ff;
      count_step = count_ff;
      if (take) begin
         window_in[0] = s1_byte_ff;
         for (int j = 1; j < NEEDLE_BYTES; j++) begin
            window_in[j] = window_ff[j-1];
         end
         count_step = count_ff + CNT_W'(1);
      end
      eq_hit = 1'b0;
      for (int l = 1; l <= NEEDLE_BYTES; l++) begin
         eq_l = 1'b1;
         for (int k = 0; k < l; k++) begin
            if (window_in[l-1-k] != needle_arr[k]) begin
               eq_l = 1'b0;
            end
         end
         if (32'(len_act) == l && eq_l) begin
            eq_hit = 1'b1;
         end
      end
      pos       = count_step - CNT_W'(len_act);
      pos_ext   = CMP_W'(pos);
      start_ext = CMP_W'(start_ff);
      hit       = take && (len_act != '0) && (count_step >= CNT_W'(len_act)) && eq_hit &&
                  (pos_ext >= start_ext);
      seen_step = seen_ff || hit;
      best_step = (hit && (mode_ff || !seen_ff)) ? pos_ext[sse_pkg::POS_W-1:0] : best_ff;
      ovf_step  = ovf_ff || (s1_has_ff && full);

      count_ext = CMP_W'(count_step);
      empty_pos = (start_ext <= count_ext) ? start_ext : count_ext;
      if (len_act == '0) begin
         found   = 1'b1;
         out_pos = empty_pos[sse_pkg::POS_W-1:0];
      end else if (seen_step) begin
         found   = 1'b1;
         out_pos = best_step;
      end else begin
         found   = 1'b0;
         out_pos = '0;
      end
      rsp_data_in = {1'b0, ovf_step, out_pos, found};

      count_in = count_step;
      seen_in  = seen_step;
      best_in  = best_step;
      ovf_in   = ovf_step;
      if (s1_eot_ff) begin
         for (int j = 0; j < NEEDLE_BYTES; j++) begin
            window_in[j] = 8'd0;
         end
         count_in = '0;
         seen_in  = 1'b0;
         best_in  = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NEEDLE_BYTES; j++) begin
            window_ff[j] <= 8'd0;
         end
         count_ff <= '0;
         seen_ff  <= 1'b0;
         best_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else if (s1_adv) begin
         window_ff <= window_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
         best_ff   <= best_in;
         ovf_ff    <= ovf_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_adv && s1_eot_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_eot_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SSE_ASSERT_NEXT(a_rsp_from_eot, clock, reset, !rsp_valid_ff && !(s1_adv && s1_eot_ff), !rsp_valid_ff, "result appeared without end of text")
   `SSE_ASSERT_NEXT(a_clear_after_eot, clock, reset, s1_adv && s1_eot_ff, count_ff == '0 && !seen_ff && !ovf_ff, "text state not cleared after end of text")
   `SSE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_MAX, "byte count beyond maximum length")
   `SSE_ASSERT_NOW(a_no_eot_overwrite, clock, reset, s1_adv && s1_eot_ff, !rsp_valid_ff || rsp_tready, "pending result overwritten")

endmodule
`default_nettype wire
